@@ design/nearest_neighbor_image_scaler_core_macros.svh @@
// Assertion macros shared by the scaler checker
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_CORE_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define NNIS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scaler assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define NNIS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scaler assertion failed");

`endif

@@ design/nnis_pkg.sv @@
// Package with types and constants of the nearest-neighbor scaler
`timescale 1ns / 1ps
package nnis_pkg;

	localparam int FRAME_PIXELS = 65536;
	localparam int ADDR_W       = 16;
	localparam int MAX_DIM      = 4096;
	localparam int DIM_W        = 13;
	localparam int COORD_W      = 12;
	localparam int PITCH_W      = 17;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 17;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y   = 3'd6;

	// operation codes of an input word
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	// one stored pixel, red in the low byte
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// clamp a size register into 1..MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

endpackage

@@ design/nnis_if.sv @@
// Channel interfaces of the scaler: pixel input, pixel output, configuration
`timescale 1ns / 1ps
interface nnis_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] load_address;
	logic [7:0]  load_red;
	logic [7:0]  load_green;
	logic [7:0]  load_blue;
	logic [7:0]  load_alpha;

	modport source (output valid, operation, load_address, load_red, load_green,
		load_blue, load_alpha, input ready);
	modport sink (input valid, operation, load_address, load_red, load_green,
		load_blue, load_alpha, output ready);
endinterface

interface nnis_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [11:0] dest_x;
	logic [11:0] dest_y;
	logic        last_of_frame;

	modport source (output valid, red, green, blue, alpha, dest_x, dest_y,
		last_of_frame, input ready);
	modport sink (input valid, red, green, blue, alpha, dest_x, dest_y,
		last_of_frame, output ready);
endinterface

interface nnis_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [16:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/nearest_neighbor_image_scaler_core.sv @@
// Nearest-neighbor RGBA scaler: frame store, coordinate sequencer and serial divider.
// A load word is written to the frame store; the block stays idle and ready.
// An emit word runs multiply, a 12-step division on the one shared restoring
// divider, then saturate and mirror, for the column and then the row, then the
// address and read steps; no new word is taken until its result enters the output register.
// arst_n clears the sequencer, counters, config (sizes and pitch 1, mirrors 0);
// the frame store is not cleared and holds garbage until written.
`timescale 1ns / 1ps
module nearest_neighbor_image_scaler_core (
	input  logic         clk,
	input  logic         arst_n,
	nnis_in_if.sink      pix_in,
	nnis_out_if.source   pix_out,
	nnis_cfg_if.sink     cfg
);
	import nnis_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_DIV  = 7'b0000100,
		ST_FIX  = 7'b0001000,
		ST_ADDR = 7'b0010000,
		ST_READ = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [DIM_W-1:0]   src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [PITCH_W-1:0] row_pitch_q;
	logic               mirror_x_q, mirror_y_q;

	// raster counters and the captured coordinate of the word in flight
	logic [COORD_W-1:0] col_q, row_q, cur_col_q, cur_row_q;
	logic               last_q;

	// shared divider state
	logic               axis_q;
	logic               sat_q;
	logic [DIM_W-1:0]   rem_q;
	logic [COORD_W-1:0] dvd_q;
	logic [COORD_W-1:0] quo_q;
	logic [3:0]         cnt_q;
	logic [COORD_W-1:0] sx_q, sy_q;
	logic [ADDR_W-1:0]  addr_q;

	// frame store and its registered read port
	pixel_t mem_q [FRAME_PIXELS];
	pixel_t rd_q;

	// output register
	logic               out_valid_q;
	pixel_t             out_pix_q;
	logic [COORD_W-1:0] out_x_q, out_y_q;
	logic               out_last_q;

	logic [DIM_W-1:0]   sw, sh, dw, dh, dw_m1, dh_m1;
	logic               in_fire, load_fire, emit_fire, out_free;
	logic               end_col, end_row;
	logic [COORD_W-1:0] u_pos;
	logic [DIM_W-1:0]   u_src, u_dst, u_src_m1;
	logic               u_mirror;
	logic [24:0]        u_prod;
	logic [DIM_W:0]     u_trial;
	logic               u_ge;
	logic [COORD_W-1:0] u_coord, u_coord_m;
	logic [28:0]        row_base;

	assign sw    = eff_dim(src_width_q);
	assign sh    = eff_dim(src_height_q);
	assign dw    = eff_dim(dst_width_q);
	assign dh    = eff_dim(dst_height_q);
	assign dw_m1 = dw - DIM_W'(1);
	assign dh_m1 = dh - DIM_W'(1);

	assign pix_in.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign in_fire      = pix_in.valid && pix_in.ready;
	assign load_fire    = in_fire && (pix_in.operation == OP_LOAD);
	assign emit_fire    = in_fire && (pix_in.operation == OP_EMIT);
	assign out_free     = !out_valid_q || pix_out.ready;

	assign end_col = {1'b0, col_q} >= dw_m1;
	assign end_row = {1'b0, row_q} >= dh_m1;

	// select the axis the shared unit works on
	always_comb begin
		u_pos    = axis_q ? cur_row_q : cur_col_q;
		u_src    = axis_q ? sh : sw;
		u_dst    = axis_q ? dh : dw;
		u_mirror = axis_q ? mirror_y_q : mirror_x_q;
		u_src_m1 = u_src - DIM_W'(1);
		u_prod   = 25'(u_src) * 25'(u_pos);
		u_trial  = {rem_q, dvd_q[COORD_W-1]};
		u_ge     = u_trial >= {1'b0, u_dst};
		u_coord  = sat_q ? u_src_m1[COORD_W-1:0] : quo_q;
		u_coord_m = u_mirror ? (u_src_m1[COORD_W-1:0] - u_coord) : u_coord;
		row_base = 29'(sy_q) * 29'(row_pitch_q);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= DIM_W'(1);
			src_height_q <= DIM_W'(1);
			dst_width_q  <= DIM_W'(1);
			dst_height_q <= DIM_W'(1);
			row_pitch_q  <= PITCH_W'(1);
			mirror_x_q   <= 1'b0;
			mirror_y_q   <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SRC_WIDTH:  src_width_q  <= cfg.data[DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg.data[DIM_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg.data[DIM_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= cfg.data[DIM_W-1:0];
				REG_ROW_PITCH:  row_pitch_q  <= cfg.data[PITCH_W-1:0];
				REG_MIRROR_X:   mirror_x_q   <= cfg.data[0];
				REG_MIRROR_Y:   mirror_y_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// sequencer, counters and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
			last_q    <= 1'b0;
			axis_q    <= 1'b0;
			sat_q     <= 1'b0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// capture the coordinate and advance the raster counters
					if (emit_fire) begin
						cur_col_q <= col_q;
						cur_row_q <= row_q;
						last_q    <= end_col && end_row;
						axis_q    <= 1'b0;
						if (!end_col) begin
							col_q <= col_q + COORD_W'(1);
						end else begin
							col_q <= '0;
							row_q <= end_row ? '0 : row_q + COORD_W'(1);
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					sat_q   <= {1'b0, u_pos} >= u_dst;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(COORD_W - 1))
						state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: state_q <= ST_READ;
				ST_READ: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider datapath and address; no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			rem_q <= u_prod[24:COORD_W];
			dvd_q <= u_prod[COORD_W-1:0];
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= u_ge ? (u_trial[DIM_W-1:0] - u_dst) : u_trial[DIM_W-1:0];
			dvd_q <= {dvd_q[COORD_W-2:0], 1'b0};
			quo_q <= {quo_q[COORD_W-2:0], u_ge};
		end
		if (state_q == ST_FIX) begin
			if (!axis_q)
				sx_q <= u_coord_m;
			else
				sy_q <= u_coord_m;
		end
		if (state_q == ST_ADDR)
			addr_q <= row_base[ADDR_W-1:0] + ADDR_W'(sx_q);
	end

	// frame store write and registered read
	always_ff @(posedge clk) begin
		if (load_fire)
			mem_q[pix_in.load_address[ADDR_W-1:0]] <= pixel_t'({pix_in.load_alpha,
				pix_in.load_blue, pix_in.load_green, pix_in.load_red});
		if (state_q == ST_READ)
			rd_q <= mem_q[addr_q];
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_FIN && out_free)
			out_valid_q <= 1'b1;
		else if (pix_out.ready)
			out_valid_q <= 1'b0;
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_pix_q  <= rd_q;
			out_x_q    <= cur_col_q;
			out_y_q    <= cur_row_q;
			out_last_q <= last_q;
		end
	end

	assign pix_out.valid         = out_valid_q;
	assign pix_out.red           = out_pix_q.red;
	assign pix_out.green         = out_pix_q.green;
	assign pix_out.blue          = out_pix_q.blue;
	assign pix_out.alpha         = out_pix_q.alpha;
	assign pix_out.dest_x        = out_x_q;
	assign pix_out.dest_y        = out_y_q;
	assign pix_out.last_of_frame = out_last_q;

endmodule

@@ design/nnis_checker.sv @@
// Port-level checker for the scaler core and its bind
`timescale 1ns / 1ps
`include "nearest_neighbor_image_scaler_core_macros.svh"
module nnis_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_operation,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);
	import nnis_pkg::*;

	// a stalled output word holds its valid
	`NNIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// an emit word occupies the divider, so input stalls right after it
	`NNIS_ASSERT_NEXT(a_emit_busy, in_valid && in_ready && (in_operation == OP_EMIT), !in_ready)
	// a load word leaves the input ready
	`NNIS_ASSERT_NEXT(a_load_fast, in_valid && in_ready && (in_operation == OP_LOAD), in_ready)
	// a new result only appears at the end of an emit, while input is stalled
	`NNIS_ASSERT_SAME(a_out_after_work, $rose(out_valid), $past(!in_ready))
	// the frame mark stays with its stalled word
	`NNIS_ASSERT_NEXT(a_last_hold, out_valid && !out_ready, $stable(out_last))

endmodule

bind nearest_neighbor_image_scaler_core nnis_checker u_nnis_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pix_in.valid),
	.in_ready     (pix_in.ready),
	.in_operation (pix_in.operation),
	.out_valid    (pix_out.valid),
	.out_ready    (pix_out.ready),
	.out_last     (pix_out.last_of_frame)
);
